/* rtl/thbs_pkg.sv */
// thbs_pkg: types, constants and codes shared by the tiled heightmap sampler.
// No dependencies; the files that use it refer to it by scoped names.
package thbs_pkg;

  localparam int TILE_SLOTS_DEF = 4;
  localparam int MAX_DIM_DEF    = 64;
  localparam int FIFO_DEPTH     = 2;

  localparam int KIND_W    = 3;
  localparam int COORD_W   = 40;
  localparam int ELEV_W    = 24;
  localparam int KEY_W     = 32;
  localparam int DIM_W     = 7;
  localparam int IDX_W     = 2 * DIM_W;
  localparam int EDGE_W    = 16;
  localparam int ORIGIN_W  = 39;
  localparam int POS_W     = 41;
  localparam int DEN_W     = 24;
  localparam int FRAC_W    = 16;
  localparam int PIX_W     = DIM_W + FRAC_W;
  localparam int WEIGHT_W  = 33;
  localparam int ACC_W     = 58;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W = 208;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  localparam logic [EDGE_W-1:0] TILE_EDGE_RESET = 16'd1000;

  localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UNLOAD   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PRESENCE = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FILL = 2'd2;

  localparam logic [1:0] REG_TILE_EDGE  = 2'd0;
  localparam logic [1:0] REG_EAST_BASE  = 2'd1;
  localparam logic [1:0] REG_NORTH_BASE = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_QUERY,
    OP_OPEN,
    OP_WRITE,
    OP_UNLOAD,
    OP_PRESENCE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_z;
    logic [ELEV_W-1:0]  default_elevation;
    logic [KEY_W-1:0]   tile_col;
    logic [KEY_W-1:0]   tile_row;
    logic [DIM_W-1:0]   tile_width;
    logic [DIM_W-1:0]   tile_height;
    logic [ELEV_W-1:0]  height_sample;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                tile_found;
    logic [ELEV_W-1:0]   elevation;
  } result_t;

  typedef struct packed {
    logic [EDGE_W-1:0]   tile_edge;
    logic [ORIGIN_W-1:0] east_base;
    logic [ORIGIN_W-1:0] north_base;
  } cfg_t;

endpackage

/* rtl/tiled_heightmap_bilinear_sampler.sv */
// tiled_heightmap_bilinear_sampler: top level with the register port and stream ports.
// Depends on thbs_pkg, thbs_front, thbs_fifo and thbs_engine.
//
// Holds up to TILE_SLOTS height tiles of at most MAX_DIM x MAX_DIM samples and
// answers one result per command. A two-entry command queue sits between the
// decoding front end and the back end, and the result sits in its own output
// register, so new commands are taken while a result waits. Open, write,
// unload, presence and unused kinds are each answered from the idle state of
// the back end. An elevation query runs a bit-serial floor division of the
// position by the tile edge, a division that scales the local offset to a
// pixel position, four reads of the sample store and a short multiply-accumulate
// pipeline for the blend. The user must write tile edge and origins through the
// register port only while no command is outstanding; the block does not enforce it.
module tiled_heightmap_bilinear_sampler #(
  parameter int TILE_SLOTS = thbs_pkg::TILE_SLOTS_DEF,
  parameter int MAX_DIM    = thbs_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // x[39:0] z[79:40] default_elevation[103:80] tile_col[135:104]
  // tile_row[167:136] tile_width[174:168] tile_height[181:175]
  // height_sample[205:182], zero pad above
  input  logic [thbs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind[2:0]
  input  logic [thbs_pkg::KIND_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // elevation[23:0] tile_found[24] status[26:25], zero pad above
  output logic [thbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [thbs_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [thbs_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [thbs_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int CMD_W = $bits(thbs_pkg::cmd_t);

  thbs_pkg::cfg_t    cfg;
  thbs_pkg::cmd_t    push_cmd;
  thbs_pkg::cmd_t    head;
  thbs_pkg::result_t res;
  logic              push, pop, full, empty;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_edge  <= thbs_pkg::TILE_EDGE_RESET;
      cfg.east_base  <= '0;
      cfg.north_base <= '0;
    end else if (cfg_we) begin
      case (paddr[4:3])
        thbs_pkg::REG_TILE_EDGE:  cfg.tile_edge  <= pwdata[thbs_pkg::EDGE_W-1:0];
        thbs_pkg::REG_EAST_BASE:  cfg.east_base  <= pwdata[thbs_pkg::ORIGIN_W-1:0];
        thbs_pkg::REG_NORTH_BASE: cfg.north_base <= pwdata[thbs_pkg::ORIGIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      thbs_pkg::REG_TILE_EDGE:  prdata = thbs_pkg::CFG_DATA_W'(cfg.tile_edge);
      thbs_pkg::REG_EAST_BASE:  prdata = thbs_pkg::CFG_DATA_W'(cfg.east_base);
      thbs_pkg::REG_NORTH_BASE: prdata = thbs_pkg::CFG_DATA_W'(cfg.north_base);
      default:                  prdata = '0;
    endcase
  end

  thbs_front #(.MAX_DIM(MAX_DIM)) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .full         (full),
    .push         (push),
    .cmd          (push_cmd)
  );

  thbs_fifo #(.W(CMD_W), .DEPTH(thbs_pkg::FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_data (head),
    .empty    (empty)
  );

  thbs_engine #(.TILE_SLOTS(TILE_SLOTS), .MAX_DIM(MAX_DIM)) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .res      (res),
    .res_valid(m_axis_tvalid),
    .res_ready(m_axis_tready)
  );

  assign m_axis_tdata = {5'b00000, res.status, res.tile_found, res.elevation};

endmodule

/* rtl/thbs_fifo.sv */
// thbs_fifo: short command queue between the front end and the back end.
// Depends on nothing but its parameters.
module thbs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/thbs_front.sv */
// thbs_front: takes stream transactions, decodes the kind and clamps tile sizes.
// Depends on thbs_pkg; feeds thbs_fifo.
module thbs_front #(
  parameter int MAX_DIM = thbs_pkg::MAX_DIM_DEF
) (
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // x[39:0] z[79:40] default[103:80] col[135:104] row[167:136]
  // width[174:168] height[181:175] sample[205:182], zero pad above
  input  logic [thbs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // kind[2:0]
  input  logic [thbs_pkg::KIND_W-1:0]      s_axis_tuser,
  input  logic                             full,
  output logic                             push,
  output thbs_pkg::cmd_t                   cmd
);

  function automatic logic [thbs_pkg::DIM_W-1:0] clamp_dim(
    input logic [thbs_pkg::DIM_W-1:0] v
  );
    logic [thbs_pkg::DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = thbs_pkg::DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = thbs_pkg::DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  always_comb begin
    case (s_axis_tuser)
      thbs_pkg::KIND_QUERY:    cmd.op = thbs_pkg::OP_QUERY;
      thbs_pkg::KIND_OPEN:     cmd.op = thbs_pkg::OP_OPEN;
      thbs_pkg::KIND_WRITE:    cmd.op = thbs_pkg::OP_WRITE;
      thbs_pkg::KIND_UNLOAD:   cmd.op = thbs_pkg::OP_UNLOAD;
      thbs_pkg::KIND_PRESENCE: cmd.op = thbs_pkg::OP_PRESENCE;
      default:                 cmd.op = thbs_pkg::OP_NOP;
    endcase
    cmd.coord_x           = s_axis_tdata[39:0];
    cmd.coord_z           = s_axis_tdata[79:40];
    cmd.default_elevation = s_axis_tdata[103:80];
    cmd.tile_col          = s_axis_tdata[135:104];
    cmd.tile_row          = s_axis_tdata[167:136];
    cmd.tile_width        = clamp_dim(s_axis_tdata[174:168]);
    cmd.tile_height       = clamp_dim(s_axis_tdata[181:175]);
    cmd.height_sample     = s_axis_tdata[205:182];
  end

endmodule

/* rtl/thbs_div.sv */
// thbs_div: restoring divider, one quotient bit per cycle.
// Standalone; the caller guarantees the start remainder is below the divisor.
module thbs_div #(
  parameter int NQ = 41,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] rem_init,
  input  logic [NQ-1:0] num_lo,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NQ-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CNT_W = $clog2(NQ + 1);

  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DW:0]      trial;
  logic             ge;

  assign trial = {rem, quo[NQ-1]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(NQ);
        rem     <= rem_init;
        quo     <= num_lo;
      end else if (running) begin
        rem <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
        quo <= {quo[NQ-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/thbs_engine.sv */
// thbs_engine: tile table, sample store, tile and pixel division, bilinear blend.
// Depends on thbs_pkg and thbs_div; holds the result register.
module thbs_engine #(
  parameter int TILE_SLOTS = thbs_pkg::TILE_SLOTS_DEF,
  parameter int MAX_DIM    = thbs_pkg::MAX_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  thbs_pkg::cfg_t     cfg,
  input  thbs_pkg::cmd_t     head,
  input  logic               empty,
  output logic               pop,
  output thbs_pkg::result_t  res,
  output logic               res_valid,
  input  logic               res_ready
);

  localparam int SW    = (TILE_SLOTS > 1) ? $clog2(TILE_SLOTS) : 1;
  localparam int MD2   = MAX_DIM * MAX_DIM;
  localparam int DEPTH = TILE_SLOTS * MD2;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] MD2_A = AW'(MD2);
  localparam int DIM_W = thbs_pkg::DIM_W;
  localparam int IDX_W = thbs_pkg::IDX_W;
  localparam int POS_W = thbs_pkg::POS_W;
  localparam int DEN_W = thbs_pkg::DEN_W;
  localparam int PIX_W = thbs_pkg::PIX_W;
  localparam int ACC_W = thbs_pkg::ACC_W;
  localparam int ELEV_W = thbs_pkg::ELEV_W;
  localparam int KEY_W = thbs_pkg::KEY_W;
  localparam int FRAC_W = thbs_pkg::FRAC_W;
  localparam int WEIGHT_W = thbs_pkg::WEIGHT_W;
  localparam int SC_W  = DEN_W + DIM_W;
  localparam int EDGE_W_FIX = thbs_pkg::EDGE_W;
  localparam int WP_W  = 2 * FRAC_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_SPLIT, S_DIV, S_LOCATE, S_SCALE, S_PIXGO, S_PIX, S_FETCH, S_DRAIN, S_FINISH
  } state_t;

  state_t state;

  logic             slot_valid  [TILE_SLOTS];
  logic [KEY_W-1:0] slot_col    [TILE_SLOTS];
  logic [KEY_W-1:0] slot_row    [TILE_SLOTS];
  logic [DIM_W-1:0] slot_width  [TILE_SLOTS];
  logic [DIM_W-1:0] slot_height [TILE_SLOTS];

  logic [ELEV_W-1:0] height_store [DEPTH];

  logic [SW-1:0]    fill_slot;
  logic [IDX_W-1:0] fill_index;
  logic [IDX_W-1:0] fill_total;
  logic             fill_open;

  logic [ELEV_W-1:0] cur_default;
  logic [POS_W-1:0]  e_pos;
  logic [POS_W-1:0]  n_pos;
  logic [KEY_W-1:0]  key_e;
  logic [KEY_W-1:0]  key_n;
  logic [DEN_W-1:0]  loc_e;
  logic [DEN_W-1:0]  loc_n;
  logic [SW-1:0]     q_slot;
  logic [DIM_W-1:0]  q_w;
  logic [DIM_W-1:0]  q_h;
  logic [SC_W-1:0]   sc_x;
  logic [SC_W-1:0]   sc_z;
  logic [DIM_W-1:0]  x0, x1, z0, z1;
  logic [FRAC_W-1:0] fx, fz;
  logic [1:0]        rd_cnt;
  logic              v1, v2;
  logic [WEIGHT_W-1:0] weight1;
  logic [ELEV_W-1:0] rd_data;
  logic signed [ACC_W-1:0] prod2;
  logic signed [ACC_W-1:0] acc;
  logic [2:0]        term_cnt;

  // lookup
  logic [KEY_W-1:0] key_col, key_row;
  logic             hit, free;
  logic [SW-1:0]    hit_idx, free_idx, open_slot;
  logic             out_free;
  logic             idle_found;
  logic [thbs_pkg::STATUS_W-1:0] idle_status;

  // division
  logic [DEN_W-1:0] den;
  logic [EDGE_W_FIX-1:0] edge_m;
  logic [POS_W-1:0] e_mag, n_mag;
  logic             div_done, pix_done;
  logic [POS_W-1:0] quo_e, quo_n;
  logic [DEN_W-1:0] rr_e, rr_n;
  logic [PIX_W-1:0] quo_px, quo_pz;
  logic [KEY_W-1:0] key_e_next, key_n_next;
  logic [DEN_W-1:0] loc_e_next, loc_n_next;
  logic [DIM_W-1:0] x0_c, z0_c;

  // fetch
  logic [DIM_W-1:0] sx, sz;
  logic [IDX_W-1:0] off;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             st_we;
  logic [FRAC_W:0]  gx, gz, wa, wb;
  logic [WP_W-1:0]  weight_next;
  logic signed [ACC_W-1:0] samp_ext, weight_ext, biased;

  assign out_free = !res_valid || res_ready;
  assign pop      = (state == S_IDLE) && !empty && out_free;

  assign key_col = (state == S_LOCATE) ? key_e : head.tile_col;
  assign key_row = (state == S_LOCATE) ? key_n : head.tile_row;

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    // descending so the lowest slot wins
    for (int i = TILE_SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_col[i] == key_col && slot_row[i] == key_row) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
      if (!slot_valid[i]) begin
        free     = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign open_slot = hit ? hit_idx : free_idx;

  // result fields of the kinds answered from the idle state
  always_comb begin
    idle_found  = 1'b0;
    idle_status = thbs_pkg::STATUS_OK;
    case (head.op)
      thbs_pkg::OP_OPEN: begin
        idle_found = hit;
        if (!(hit || free)) begin
          idle_status = thbs_pkg::STATUS_FULL;
        end
      end
      thbs_pkg::OP_WRITE: begin
        if (!fill_open) begin
          idle_status = thbs_pkg::STATUS_NO_FILL;
        end
      end
      thbs_pkg::OP_UNLOAD, thbs_pkg::OP_PRESENCE: begin
        idle_found = hit;
      end
      default: begin
      end
    endcase
  end

  // zero tile edge counts as one metre
  assign edge_m = (cfg.tile_edge == '0) ? EDGE_W_FIX'(1) : cfg.tile_edge;
  assign den    = {edge_m, 8'h00};
  assign e_mag  = e_pos[POS_W-1] ? (-e_pos) : e_pos;
  assign n_mag  = n_pos[POS_W-1] ? (-n_pos) : n_pos;

  thbs_div #(.NQ(POS_W), .DW(DEN_W)) u_div_e (
    .clk(clk), .rst(rst), .start(state == S_SPLIT), .rem_init('0), .num_lo(e_mag),
    .den(den), .done(div_done), .quo(quo_e), .rem(rr_e)
  );
  thbs_div #(.NQ(POS_W), .DW(DEN_W)) u_div_n (
    .clk(clk), .rst(rst), .start(state == S_SPLIT), .rem_init('0), .num_lo(n_mag),
    .den(den), .done(), .quo(quo_n), .rem(rr_n)
  );
  thbs_div #(.NQ(PIX_W), .DW(DEN_W)) u_div_px (
    .clk(clk), .rst(rst), .start(state == S_PIXGO), .rem_init(sc_x[SC_W-1:DIM_W]),
    .num_lo({sc_x[DIM_W-1:0], {FRAC_W{1'b0}}}), .den(den), .done(pix_done),
    .quo(quo_px), .rem()
  );
  thbs_div #(.NQ(PIX_W), .DW(DEN_W)) u_div_pz (
    .clk(clk), .rst(rst), .start(state == S_PIXGO), .rem_init(sc_z[SC_W-1:DIM_W]),
    .num_lo({sc_z[DIM_W-1:0], {FRAC_W{1'b0}}}), .den(den), .done(),
    .quo(quo_pz), .rem()
  );

  // floor correction for negative positions
  always_comb begin
    key_e_next = quo_e[KEY_W-1:0];
    loc_e_next = rr_e;
    if (e_pos[POS_W-1] && rr_e != '0) begin
      key_e_next = ~quo_e[KEY_W-1:0];
      loc_e_next = den - rr_e;
    end else if (e_pos[POS_W-1]) begin
      key_e_next = KEY_W'(0) - quo_e[KEY_W-1:0];
    end
    key_n_next = quo_n[KEY_W-1:0];
    loc_n_next = rr_n;
    if (n_pos[POS_W-1] && rr_n != '0) begin
      key_n_next = ~quo_n[KEY_W-1:0];
      loc_n_next = den - rr_n;
    end else if (n_pos[POS_W-1]) begin
      key_n_next = KEY_W'(0) - quo_n[KEY_W-1:0];
    end
  end

  assign x0_c = (quo_px[PIX_W-1:FRAC_W] >= q_w) ? q_w - DIM_W'(1) : quo_px[PIX_W-1:FRAC_W];
  assign z0_c = (quo_pz[PIX_W-1:FRAC_W] >= q_h) ? q_h - DIM_W'(1) : quo_pz[PIX_W-1:FRAC_W];

  // corner order: (x0,z0) (x1,z0) (x0,z1) (x1,z1)
  assign sx      = rd_cnt[0] ? x1 : x0;
  assign sz      = rd_cnt[1] ? z1 : z0;
  assign off     = IDX_W'(sz) * IDX_W'(q_w) + {{DIM_W{1'b0}}, sx};
  assign rd_addr = AW'(q_slot) * MD2_A + AW'(off);
  assign wr_addr = AW'(fill_slot) * MD2_A + AW'(fill_index);
  assign st_we   = pop && (head.op == thbs_pkg::OP_WRITE) && fill_open;

  assign gx          = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, fx};
  assign gz          = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, fz};
  assign wa          = rd_cnt[0] ? {1'b0, fx} : gx;
  assign wb          = rd_cnt[1] ? {1'b0, fz} : gz;
  assign weight_next = WP_W'(wa) * WP_W'(wb);

  assign samp_ext   = {{(ACC_W - ELEV_W){rd_data[ELEV_W-1]}}, rd_data};
  assign weight_ext = {{(ACC_W - WEIGHT_W){1'b0}}, weight1};
  // round to nearest, halves up
  assign biased     = acc + (ACC_W'(1) <<< 31);

  always_ff @(posedge clk) begin
    if (st_we) begin
      height_store[wr_addr] <= head.height_sample;
    end
    rd_data <= height_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      for (int i = 0; i < TILE_SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
      end
      fill_slot  <= '0;
      fill_index <= '0;
      fill_open  <= 1'b0;
      res_valid  <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      term_cnt   <= '0;
      rd_cnt     <= '0;
    end else begin
      if (res_valid && res_ready && !pop) begin
        res_valid <= 1'b0;
      end

      v1      <= (state == S_FETCH);
      weight1 <= weight_next[WEIGHT_W-1:0];
      v2      <= v1;
      if (v1) begin
        prod2 <= samp_ext * weight_ext;
      end
      if (v2) begin
        acc      <= acc + prod2;
        term_cnt <= term_cnt + 3'd1;
      end

      case (state)
        S_IDLE: begin
          if (pop) begin
            res.elevation  <= '0;
            res.tile_found <= idle_found;
            res.status     <= idle_status;
            res_valid      <= (head.op != thbs_pkg::OP_QUERY);
            case (head.op)
              thbs_pkg::OP_QUERY: begin
                cur_default <= head.default_elevation;
                e_pos <= {2'b00, cfg.east_base} - {head.coord_x[39], head.coord_x};
                n_pos <= {head.coord_z[39], head.coord_z} + {2'b00, cfg.north_base};
                state <= S_SPLIT;
              end
              thbs_pkg::OP_OPEN: begin
                if (hit || free) begin
                  slot_valid[open_slot]  <= 1'b0;
                  slot_col[open_slot]    <= head.tile_col;
                  slot_row[open_slot]    <= head.tile_row;
                  slot_width[open_slot]  <= head.tile_width;
                  slot_height[open_slot] <= head.tile_height;
                  fill_slot  <= open_slot;
                  fill_index <= '0;
                  fill_total <= IDX_W'(head.tile_width) * IDX_W'(head.tile_height);
                  fill_open  <= 1'b1;
                end
              end
              thbs_pkg::OP_WRITE: begin
                if (fill_open) begin
                  fill_index <= fill_index + IDX_W'(1);
                  if (fill_index + IDX_W'(1) >= fill_total) begin
                    slot_valid[fill_slot] <= 1'b1;
                    fill_open             <= 1'b0;
                  end
                end
              end
              thbs_pkg::OP_UNLOAD: begin
                if (hit) begin
                  slot_valid[hit_idx] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SPLIT: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            key_e <= key_e_next;
            key_n <= key_n_next;
            loc_e <= loc_e_next;
            loc_n <= loc_n_next;
            state <= S_LOCATE;
          end
        end
        S_LOCATE: begin
          if (!hit) begin
            res.elevation  <= cur_default;
            res.tile_found <= 1'b0;
            res.status     <= thbs_pkg::STATUS_OK;
            res_valid      <= 1'b1;
            state          <= S_IDLE;
          end else begin
            q_slot <= hit_idx;
            q_w    <= slot_width[hit_idx];
            q_h    <= slot_height[hit_idx];
            state  <= S_SCALE;
          end
        end
        S_SCALE: begin
          sc_x  <= SC_W'(loc_e) * SC_W'(q_w - DIM_W'(1));
          sc_z  <= SC_W'(loc_n) * SC_W'(q_h - DIM_W'(1));
          state <= S_PIXGO;
        end
        S_PIXGO: begin
          state <= S_PIX;
        end
        S_PIX: begin
          if (pix_done) begin
            x0 <= x0_c;
            z0 <= z0_c;
            x1 <= ({1'b0, x0_c} + 8'd1 < {1'b0, q_w}) ? x0_c + DIM_W'(1) : q_w - DIM_W'(1);
            z1 <= ({1'b0, z0_c} + 8'd1 < {1'b0, q_h}) ? z0_c + DIM_W'(1) : q_h - DIM_W'(1);
            fx <= quo_px[FRAC_W-1:0];
            fz <= quo_pz[FRAC_W-1:0];
            acc      <= '0;
            term_cnt <= '0;
            rd_cnt   <= '0;
            state    <= S_FETCH;
          end
        end
        S_FETCH: begin
          rd_cnt <= rd_cnt + 2'd1;
          if (rd_cnt == 2'd3) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (term_cnt == 3'd4) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            res.elevation  <= biased[ELEV_W+31:32];
            res.tile_found <= 1'b1;
            res.status     <= thbs_pkg::STATUS_OK;
            res_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* verif/tiled_heightmap_bilinear_sampler_tb.sv */
// tiled_heightmap_bilinear_sampler_tb: self-checking bench for the tiled heightmap sampler.
// Needs thbs_pkg and the sampler rtl; a scoreboard class predicts every result transaction.
module tiled_heightmap_bilinear_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 4;
  localparam int DIM = 64;
  localparam longint CYCLE_LIMIT = 1500000;
  localparam int ITEM_TARGET = 1400;

  typedef struct {
    bit [2:0] kind;
    bit [39:0] x;
    bit [39:0] z;
    bit [23:0] dflt;
    bit [31:0] col;
    bit [31:0] row;
    bit [6:0] w;
    bit [6:0] h;
    bit [23:0] samp;
  } hm_cmd_t;

  class heightmap_scoreboard;
    bit [15:0] tile_edge;
    bit [38:0] org_east;
    bit [38:0] org_north;
    bit slot_ok[SLOTS];
    bit [31:0] slot_c[SLOTS];
    bit [31:0] slot_r[SLOTS];
    int slot_w[SLOTS];
    int slot_h[SLOTS];
    bit [23:0] heights[SLOTS*DIM*DIM];
    int fill_slot;
    int fill_idx;
    bit fill_on;
    thbs_pkg::result_t awaited[$];
    int errors;
    int checked;

    function new();
      tile_edge = thbs_pkg::TILE_EDGE_RESET;
      org_east = 0;
      org_north = 0;
      foreach (slot_ok[i]) slot_ok[i] = 0;
      fill_slot = 0;
      fill_idx = 0;
      fill_on = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, longint unsigned v);
      case (idx)
        thbs_pkg::REG_TILE_EDGE: tile_edge = v[15:0];
        thbs_pkg::REG_EAST_BASE: org_east = v[38:0];
        thbs_pkg::REG_NORTH_BASE: org_north = v[38:0];
        default: ;
      endcase
    endfunction

    function int lookup(bit [31:0] c, bit [31:0] r);
      for (int i = 0; i < SLOTS; i++)
        if (slot_ok[i] && slot_c[i] == c && slot_r[i] == r) return i;
      return -1;
    endfunction

    function longint floor_quot(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function longint px(int s, int xi, int zi);
      longint v;
      v = $signed(heights[s*DIM*DIM + zi*slot_w[s] + xi]);
      return v;
    endfunction

    function thbs_pkg::result_t elevation_at(hm_cmd_t it);
      thbs_pkg::result_t res;
      longint xs, zs, edge_u, e, n, qe, qn, pxf, pzf, fx, fz, gx, gz, acc, biased;
      int s, w, h, x0, z0, x1, z1;
      bit [63:0] qe_b, qn_b;
      res = '0;
      xs = $signed(it.x);
      zs = $signed(it.z);
      edge_u = longint'(tile_edge == 0 ? 16'd1 : tile_edge) * 256;
      e = longint'(org_east) - xs;
      n = zs + longint'(org_north);
      qe = floor_quot(e, edge_u);
      qn = floor_quot(n, edge_u);
      qe_b = qe;
      qn_b = qn;
      s = lookup(qe_b[31:0], qn_b[31:0]);
      if (s < 0) begin
        res.elevation = it.dflt;
        return res;
      end
      res.tile_found = 1'b1;
      w = slot_w[s];
      h = slot_h[s];
      pxf = (((e - qe * edge_u) * (w - 1)) << 16) / edge_u;
      pzf = (((n - qn * edge_u) * (h - 1)) << 16) / edge_u;
      x0 = int'(pxf >> 16);
      z0 = int'(pzf >> 16);
      if (x0 >= w) x0 = w - 1;
      if (z0 >= h) z0 = h - 1;
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      z1 = (z0 + 1 < h) ? z0 + 1 : h - 1;
      fx = pxf & 64'hFFFF;
      fz = pzf & 64'hFFFF;
      gx = 65536 - fx;
      gz = 65536 - fz;
      acc = px(s, x0, z0) * (gx * gz) + px(s, x1, z0) * (fx * gz)
          + px(s, x0, z1) * (gx * fz) + px(s, x1, z1) * (fx * fz);
      // bias keeps the sum positive so the shift rounds half up
      biased = acc + (longint'(1) << 55) + (longint'(1) << 31);
      biased = (biased >> 32) - (longint'(1) << 23);
      res.elevation = biased[23:0];
      return res;
    endfunction

    function int clamp_dim(bit [6:0] v);
      if (v < 1) return 1;
      if (v > DIM) return DIM;
      return v;
    endfunction

    function void note_command(hm_cmd_t it);
      thbs_pkg::result_t res;
      int s;
      res = '0;
      case (it.kind)
        thbs_pkg::KIND_QUERY: res = elevation_at(it);
        thbs_pkg::KIND_OPEN: begin
          s = lookup(it.col, it.row);
          res.tile_found = (s >= 0);
          if (s < 0)
            for (int i = SLOTS - 1; i >= 0; i--) if (!slot_ok[i]) s = i;
          if (s < 0) begin
            res.status = thbs_pkg::STATUS_FULL;
          end else begin
            slot_ok[s] = 0;
            slot_c[s] = it.col;
            slot_r[s] = it.row;
            slot_w[s] = clamp_dim(it.w);
            slot_h[s] = clamp_dim(it.h);
            fill_slot = s;
            fill_idx = 0;
            fill_on = 1;
          end
        end
        thbs_pkg::KIND_WRITE: begin
          if (!fill_on) begin
            res.status = thbs_pkg::STATUS_NO_FILL;
          end else begin
            heights[fill_slot*DIM*DIM + fill_idx] = it.samp;
            fill_idx++;
            if (fill_idx >= slot_w[fill_slot] * slot_h[fill_slot]) begin
              slot_ok[fill_slot] = 1;
              fill_on = 0;
            end
          end
        end
        thbs_pkg::KIND_UNLOAD: begin
          s = lookup(it.col, it.row);
          res.tile_found = (s >= 0);
          if (s >= 0) slot_ok[s] = 0;
        end
        thbs_pkg::KIND_PRESENCE: res.tile_found = (lookup(it.col, it.row) >= 0);
        default: ;
      endcase
      awaited.push_back(res);
    endfunction

    function void check_result(logic [31:0] d);
      thbs_pkg::result_t exp_r;
      if (awaited.size() == 0) begin
        $display("%0t: result %h with nothing outstanding", $time, d);
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      checked++;
      if (d[23:0] !== exp_r.elevation) begin
        $display("%0t: elevation expected %0d actual %0d", $time,
                 $signed(exp_r.elevation), $signed(d[23:0]));
        errors++;
      end
      if (d[24] !== exp_r.tile_found) begin
        $display("%0t: tile_found expected %0b actual %0b", $time, exp_r.tile_found, d[24]);
        errors++;
      end
      if (d[26:25] !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, d[26:25]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [thbs_pkg::IN_DATA_W-1:0] s_axis_tdata;
  logic [thbs_pkg::KIND_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [thbs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic psel, penable, pwrite, pready;
  logic [thbs_pkg::CFG_ADDR_W-1:0] paddr;
  logic [thbs_pkg::CFG_DATA_W-1:0] pwdata, prdata;

  heightmap_scoreboard sb = new();
  bit gaps_on = 1;
  int items_sent = 0;
  int stall_left = 0;
  longint cycles = 0;

  tiled_heightmap_bilinear_sampler uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tiled_heightmap_bilinear_sampler_tb: errors");
      $finish;
    end
  end

  // result side: check, then random stall bursts
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(hm_cmd_t it);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.kind;
    s_axis_tdata <= {2'b00, it.samp, it.h, it.w, it.row, it.col, it.dflt, it.z, it.x};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_command(it);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, longint unsigned v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= thbs_pkg::CFG_ADDR_W'(idx * 8);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  function automatic hm_cmd_t noise_cmd(bit [2:0] k);
    hm_cmd_t it;
    it.kind = k;
    it.x = 40'({$urandom, $urandom});
    it.z = 40'({$urandom, $urandom});
    it.dflt = 24'($urandom);
    it.col = $urandom;
    it.row = $urandom;
    it.w = 7'($urandom);
    it.h = 7'($urandom);
    it.samp = 24'($urandom);
    return it;
  endfunction

  function automatic hm_cmd_t key_cmd(bit [2:0] k, int c, int r, int w, int h);
    hm_cmd_t it;
    it = noise_cmd(k);
    it.col = c;
    it.row = r;
    it.w = 7'(w);
    it.h = 7'(h);
    return it;
  endfunction

  // query aimed inside tile (c,r); off < 0 picks a random offset
  function automatic hm_cmd_t aimed_query(int c, int r, longint offx, longint offz);
    hm_cmd_t it;
    longint edge_u, e, n, xv, zv;
    it = noise_cmd(thbs_pkg::KIND_QUERY);
    edge_u = longint'(sb.tile_edge == 0 ? 16'd1 : sb.tile_edge) * 256;
    if (offx < 0) offx = (longint'($urandom) << 8 ^ $urandom) % edge_u;
    if (offz < 0) offz = (longint'($urandom) << 8 ^ $urandom) % edge_u;
    e = longint'(c) * edge_u + offx;
    n = longint'(r) * edge_u + offz;
    xv = longint'(sb.org_east) - e;
    zv = n - longint'(sb.org_north);
    it.x = xv[39:0];
    it.z = zv[39:0];
    return it;
  endfunction

  task automatic fill_tile(int c, int r, int w, int h, int count);
    hm_cmd_t it;
    send_cmd(key_cmd(thbs_pkg::KIND_OPEN, c, r, w, h));
    for (int i = 0; i < count; i++) begin
      it = noise_cmd(thbs_pkg::KIND_WRITE);
      send_cmd(it);
    end
  endtask

  task automatic random_step();
    int pick, c, r, w, h, n;
    hm_cmd_t it;
    pick = $urandom_range(0, 99);
    c = $signed($urandom_range(0, 4)) - 2;
    r = $signed($urandom_range(0, 4)) - 2;
    if (pick < 25) begin
      w = $urandom_range(1, 5);
      h = $urandom_range(1, 5);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
      if (w > 64) h = $urandom_range(0, 1);
      n = sb.clamp_dim(7'(w)) * sb.clamp_dim(7'(h));
      // now and then a fill is abandoned or overrun
      if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n + 2);
      fill_tile(c, r, w, h, n);
    end else if (pick < 65) begin
      case ($urandom_range(0, 3))
        0: send_cmd(aimed_query(c, r, 0, 0));
        default: send_cmd(aimed_query(c, r, -1, -1));
      endcase
    end else if (pick < 78) begin
      send_cmd(key_cmd($urandom_range(0, 1) ? thbs_pkg::KIND_UNLOAD : thbs_pkg::KIND_PRESENCE,
                       c, r, 1, 1));
    end else if (pick < 86) begin
      send_cmd(noise_cmd(thbs_pkg::KIND_WRITE));
    end else begin
      it = noise_cmd(3'($urandom_range(0, 7)));
      // an open from noise must not start a huge fill
      if (it.kind == thbs_pkg::KIND_OPEN) it.h = 7'd1;
      send_cmd(it);
    end
  endtask

  initial begin
    longint unsigned edges[5];
    longint unsigned easts[5];
    longint unsigned norths[5];
    hm_cmd_t it;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under reset configuration
    send_cmd(noise_cmd(thbs_pkg::KIND_WRITE));
    for (int k = 5; k < 8; k++) send_cmd(noise_cmd(3'(k)));
    send_cmd(key_cmd(thbs_pkg::KIND_PRESENCE, 0, 0, 1, 1));
    send_cmd(key_cmd(thbs_pkg::KIND_OPEN, 0, 0, 2, 2));
    it = noise_cmd(thbs_pkg::KIND_WRITE); it.samp = 24'h7FFFFF; send_cmd(it);
    it.samp = 24'h800000; send_cmd(it);
    it.samp = 24'h000000; send_cmd(it);
    it.samp = 24'hFFFFFF; send_cmd(it);
    send_cmd(noise_cmd(thbs_pkg::KIND_WRITE));
    send_cmd(aimed_query(0, 0, 0, 0));
    send_cmd(aimed_query(0, 0, 255999, 255999));
    send_cmd(aimed_query(0, 0, 128000, 128000));
    fill_tile(-1, -1, 0, 0, 1);
    send_cmd(aimed_query(-1, -1, -1, -1));
    fill_tile(1, 0, 3, 3, 4);
    fill_tile(1, 0, 3, 1, 3);
    fill_tile(-1, -1, 1, 2, 2);
    fill_tile(2, 2, 1, 1, 1);
    send_cmd(key_cmd(thbs_pkg::KIND_OPEN, 5, 5, 1, 1));
    send_cmd(noise_cmd(thbs_pkg::KIND_WRITE));
    send_cmd(key_cmd(thbs_pkg::KIND_UNLOAD, 9, 9, 1, 1));
    send_cmd(key_cmd(thbs_pkg::KIND_UNLOAD, 2, 2, 1, 1));
    it = noise_cmd(thbs_pkg::KIND_QUERY);
    it.x = 40'h7FFFFFFFFF; it.z = 40'h8000000000; send_cmd(it);
    drain();

    edges = '{1000, 0, 1, 65535, 0};
    easts = '{0, 39'h7FFFFFFFFF, 0, 0, 0};
    norths = '{0, 39'h7FFFFFFFFF, 0, 39'h7FFFFFFFFF, 0};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 2 || ph == 4) begin
        easts[ph] = {$urandom, $urandom} & 39'h7FFFFFFFFF;
        norths[ph] = {$urandom, $urandom} & 39'h7FFFFFFFFF;
      end
      if (ph == 4) edges[ph] = $urandom_range(1, 65535);
      reg_write(thbs_pkg::REG_TILE_EDGE, edges[ph]);
      reg_write(thbs_pkg::REG_EAST_BASE, easts[ph]);
      reg_write(thbs_pkg::REG_NORTH_BASE, norths[ph]);
      if (ph == 2) begin
        // far coordinates make the tile index wrap past 32 bits
        it = noise_cmd(thbs_pkg::KIND_QUERY);
        it.x = 40'h8000000000; it.z = 40'h7FFFFFFFFF; send_cmd(it);
        fill_tile(0, -1, 64, 2, 128);
        send_cmd(aimed_query(0, -1, -1, -1));
        fill_tile(-1, 0, 2, 64, 128);
        send_cmd(aimed_query(-1, 0, -1, -1));
      end
      if (ph == 4) gaps_on = 0;
      while (items_sent < (ph + 1) * ITEM_TARGET / 5) random_step();
      drain();
    end

    repeat (100) @(posedge clk);
    $display("%0d commands sent over 5 register settings, %0d results compared",
             items_sent, sb.checked);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("tiled_heightmap_bilinear_sampler_tb: clean");
    end else begin
      $display("tiled_heightmap_bilinear_sampler_tb: errors");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/thbs_pkg.sv
rtl/thbs_fifo.sv
rtl/thbs_front.sv
rtl/thbs_div.sv
rtl/thbs_engine.sv
rtl/tiled_heightmap_bilinear_sampler.sv
verif/tiled_heightmap_bilinear_sampler_tb.sv
